// ----- rtl/mwpo_pkg.sv -----
// ----------------------------------------------------------------------------
// mwpo_pkg: shared definitions for the multi-waveform phase oscillator
// Waveform codes, field widths, reset values and the quarter-wave sine
// table generator used at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package mwpo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int MODE_WIDTH  = 3;
    localparam int FREQ_WIDTH  = 24;
    localparam int SCALE_WIDTH = 36;
    localparam int SCALE_SPLIT = 18;
    localparam int PROD_BITS   = 56;

    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 36'd5864062015;

    localparam logic [0:0] REG_PHASE_SCALE = 1'b0;

    localparam logic [MODE_WIDTH-1:0] MODE_SINE     = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_SQUARE   = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_SAW_DOWN = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SAW_UP   = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_TRIANGLE = 3'd4;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic load_lookup;
        logic load_out;
    } wave_ctl_t;

    // quarter-wave entry k: sin(k * (pi/2) / 2^table_bits) at full scale
    function automatic logic [63:0] quarter_entry(input logic [63:0] k,
                                                  input int table_bits,
                                                  input int sample_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] max_val;
        logic [63:0] v;
        x       = (k * PI_Q30) >> (table_bits + 1);
        x2      = (x * x) >> 30;
        max_val = (64'd1 << (sample_bits - 1)) - 64'd1;
        sum     = x;
        term    = ((x * x2) >> 30) / 64'd6;
        sum     = sum - term;
        term    = ((term * x2) >> 30) / 64'd20;
        sum     = sum + term;
        term    = ((term * x2) >> 30) / 64'd42;
        sum     = sum - term;
        term    = ((term * x2) >> 30) / 64'd72;
        sum     = sum + term;
        term    = ((term * x2) >> 30) / 64'd110;
        sum     = sum - term;
        term    = ((term * x2) >> 30) / 64'd156;
        sum     = sum + term;
        term    = ((term * x2) >> 30) / 64'd210;
        sum     = sum - term;
        if (sum > ONE_Q30)
        begin
            sum = ONE_Q30;
        end
        v = (sum * max_val + (ONE_Q30 >> 1)) >> 30;
        if (v > max_val)
        begin
            v = max_val;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mwpo_wave.sv -----
// ----------------------------------------------------------------------------
// mwpo_wave: waveform shaper
// Looks up the quarter-wave sine table and forms the square, saw and
// triangle shapes from a phase word, then selects and registers the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpo_wave #(
    parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS,
    parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS,
    parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS
) (
    input  wire                               clk,
    input  wire mwpo_pkg::wave_ctl_t          ctl,
    input  wire  [PHASE_BITS-1:0]             phase,
    input  wire  [mwpo_pkg::MODE_WIDTH-1:0]   mode,
    output logic [SAMPLE_BITS-1:0]            sample
);

    localparam int P         = PHASE_BITS;
    localparam int T         = SINE_TABLE_BITS;
    localparam int S         = SAMPLE_BITS;
    localparam int W         = S + 2;
    localparam int ROM_DEPTH = (1 << T) + 1;
    localparam int HALF_I    = 1 << (S - 1);

    localparam logic [T:0]          QUARTER    = {1'b1, {T{1'b0}}};
    localparam logic [P-1:0]        HALF_PHASE = {1'b1, {(P-1){1'b0}}};
    localparam logic signed [W-1:0] H_W        = W'(HALF_I);
    localparam logic signed [W-1:0] M_W        = W'(HALF_I - 1);
    localparam logic signed [W-1:0] H3_W       = W'(3 * HALF_I);

    logic [S-2:0] rom [0:ROM_DEPTH-1];

    for (genvar k = 0; k < ROM_DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] ENTRY = mwpo_pkg::quarter_entry(64'(k), T, S);
        assign rom[k] = ENTRY[S-2:0];
    end

    logic [1:0]              quad;
    logic [T-1:0]            raw_idx;
    logic [T:0]              idx;
    logic                    at_most_half;
    logic [P+S:0]            ext;
    logic signed [W-1:0]     s_lin;
    logic signed [W-1:0]     s_dbl;
    logic signed [W-1:0]     shape;
    logic signed [W-1:0]     shape_sat;

    logic [S-2:0]                  rom_reg;
    logic                          neg_reg;
    logic [mwpo_pkg::MODE_WIDTH-1:0] mode_reg;
    logic [S-1:0]                  shape_reg;
    logic [S-1:0]                  sample_reg;
    logic [S-1:0]                  sample_next;
    logic signed [S-1:0]           rom_val;

    always_comb
    begin
        quad         = phase[P-1:P-2];
        raw_idx      = phase[P-3:P-2-T];
        idx          = quad[0] ? (QUARTER - {1'b0, raw_idx}) : {1'b0, raw_idx};
        at_most_half = (phase <= HALF_PHASE);
        ext          = {phase, {(S+1){1'b0}}};
        s_lin        = signed'(W'(ext[P+S:P+1]));
        s_dbl        = signed'(W'(ext[P+S:P]));
        case (mode)
            mwpo_pkg::MODE_SQUARE:   shape = at_most_half ? M_W : -H_W;
            mwpo_pkg::MODE_SAW_DOWN: shape = H_W - s_lin;
            mwpo_pkg::MODE_SAW_UP:   shape = s_lin - H_W;
            mwpo_pkg::MODE_TRIANGLE: shape = at_most_half ? (s_dbl - H_W) : (H3_W - s_dbl);
            default:                 shape = '0;
        endcase
        if (shape > M_W)
        begin
            shape_sat = M_W;
        end
        else if (shape < -H_W)
        begin
            shape_sat = -H_W;
        end
        else
        begin
            shape_sat = shape;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_lookup)
        begin
            rom_reg   <= rom[idx];
            neg_reg   <= quad[1];
            mode_reg  <= mode;
            shape_reg <= shape_sat[S-1:0];
        end
    end

    always_comb
    begin
        rom_val = signed'({1'b0, rom_reg});
        if (mode_reg == mwpo_pkg::MODE_SINE)
        begin
            sample_next = neg_reg ? (-rom_val) : rom_val;
        end
        else
        begin
            sample_next = shape_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

// ----- rtl/multi_waveform_phase_oscillator.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator: five-waveform numerically controlled
// oscillator
// Takes one tick per stream word (waveform in tuser, signed Q16.8 Hz
// frequency in tdata), returns one saturated signed sample per tick.
// ----------------------------------------------------------------------------
// One sample word comes out for every word taken in, and while m_tready stays
// high a new word can be taken on every clock, so the sustained rate is one
// tick per cycle. From input handshake to m_tvalid the word passes five
// registers: input register, the frequency-times-scale multiply split into
// two 24x19 partial products, the partial-product sum that forms the
// phase increment, the phase update with the sine table read, and
// the output register. The sample of a tick comes from the phase before that
// tick's increment is added. phase_scale sits at byte address 0 and should
// only be written while no ticks are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_phase_oscillator #(
    parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS,
    parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS,
    parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS
) (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [23:0] frequency
    input  wire  [2:0]  s_tuser,   // [2:0] mode

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata   // [SAMPLE_BITS-1:0] sample
);

    localparam int P       = PHASE_BITS;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MW      = mwpo_pkg::MODE_WIDTH;
    localparam int FW      = mwpo_pkg::FREQ_WIDTH;
    localparam int SW      = mwpo_pkg::SCALE_WIDTH;
    localparam int SPLIT   = mwpo_pkg::SCALE_SPLIT;
    localparam int PB      = mwpo_pkg::PROD_BITS;
    localparam int PP_W    = FW + SPLIT + 1;

    logic [SW-1:0] scale_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[3:3] == mwpo_pkg::REG_PHASE_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= mwpo_pkg::SCALE_RESET;
        end
        else if (cfg_write)
        begin
            scale_reg <= pwdata[SW-1:0];
        end
    end

    assign prdata = (paddr[3:3] == mwpo_pkg::REG_PHASE_SCALE) ? 64'(scale_reg) : 64'd0;

    logic in_valid_reg, mul_valid_reg, inc_valid_reg, look_valid_reg, out_valid_reg;
    logic in_valid_next, mul_valid_next, inc_valid_next, look_valid_next, out_valid_next;
    logic adv_in, adv_mul, adv_inc, adv_look, adv_out;
    logic phase_load;

    assign adv_out  = !out_valid_reg || m_tready;
    assign adv_look = !look_valid_reg || adv_out;
    assign adv_inc  = !inc_valid_reg || adv_look;
    assign adv_mul  = !mul_valid_reg || adv_inc;
    assign adv_in   = !in_valid_reg || adv_mul;

    assign s_tready   = adv_in;
    assign phase_load = adv_look && inc_valid_reg;

    always_comb
    begin
        in_valid_next   = adv_in   ? s_tvalid       : in_valid_reg;
        mul_valid_next  = adv_mul  ? in_valid_reg   : mul_valid_reg;
        inc_valid_next  = adv_inc  ? mul_valid_reg  : inc_valid_reg;
        look_valid_next = adv_look ? inc_valid_reg  : look_valid_reg;
        out_valid_next  = adv_out  ? look_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            mul_valid_reg  <= 1'b0;
            inc_valid_reg  <= 1'b0;
            look_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            mul_valid_reg  <= mul_valid_next;
            inc_valid_reg  <= inc_valid_next;
            look_valid_reg <= look_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    logic [MW-1:0]        in_mode_reg, mul_mode_reg, inc_mode_reg;
    logic signed [FW-1:0] in_freq_reg;
    logic signed [PP_W-1:0] mul_lo_reg, mul_hi_reg;
    logic signed [PP_W-1:0] mul_lo_next, mul_hi_next;
    logic signed [PB-1:0] inc_sum;
    logic [P-1:0]         inc_reg, inc_next;
    logic [P-1:0]         phase_reg, phase_next;

    always_comb
    begin
        mul_lo_next = in_freq_reg * signed'({1'b0, scale_reg[SPLIT-1:0]});
        mul_hi_next = in_freq_reg * signed'({1'b0, scale_reg[SW-1:SPLIT]});
        inc_sum     = PB'(mul_lo_reg) + (PB'(mul_hi_reg) <<< SPLIT);
        inc_next    = inc_sum[PB-1:PB-P];
        phase_next  = phase_reg + inc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && s_tvalid)
        begin
            in_mode_reg <= s_tuser[MW-1:0];
            in_freq_reg <= signed'(s_tdata[FW-1:0]);
        end
        if (adv_mul && in_valid_reg)
        begin
            mul_mode_reg <= in_mode_reg;
            mul_lo_reg   <= mul_lo_next;
            mul_hi_reg   <= mul_hi_next;
        end
        if (adv_inc && mul_valid_reg)
        begin
            inc_mode_reg <= mul_mode_reg;
            inc_reg      <= inc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (phase_load)
        begin
            phase_reg <= phase_next;
        end
    end

    mwpo_pkg::wave_ctl_t     wave_ctl;
    logic [SAMPLE_BITS-1:0]  sample;

    assign wave_ctl.load_lookup = phase_load;
    assign wave_ctl.load_out    = adv_out && look_valid_reg;

    mwpo_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_wave (
        .clk    (clk),
        .ctl    (wave_ctl),
        .phase  (phase_reg),
        .mode   (inc_mode_reg),
        .sample (sample)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(sample);

    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_load |=> $stable(phase_reg))
        else $error("phase moved without a tick");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_lookup_kept: assert property (@(posedge clk) disable iff (!rst_n)
        look_valid_reg && !adv_look |=> look_valid_reg)
        else $error("stalled lookup word dropped");

    a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(sample))
        else $error("stalled sample lost");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the multi-waveform phase oscillator
// Drives sample ticks (waveform in tuser, Q16.8 frequency in tdata) through
// the block, predicts every output sample with an independent phase
// accumulator and quarter-wave sine table, and checks each returned word in
// order. phase_scale is rewritten between phases (reset value, zero, all
// ones, random values) while both stream sides idle, stall and back up.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = mwpo_pkg::SAMPLE_BITS;
    localparam int TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SCALE_W      = mwpo_pkg::SCALE_WIDTH;
    localparam int FULL_SCALE   = 32768;
    localparam int MAX_SAMPLE   = 32767;
    localparam int QUARTER_SIZE = 1 << mwpo_pkg::SINE_TABLE_BITS;
    localparam int SETTLE       = 12;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [3:0] ADDR_PHASE_SCALE = {mwpo_pkg::REG_PHASE_SCALE, 3'b000};
    localparam logic [3:0] ADDR_UNMAPPED    = 4'd8;

    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    localparam logic [63:0] PI_HALF_TURN_Q30 = 64'd3373259426;
    localparam logic [63:0] UNITY_Q30        = 64'd1 << 30;
    localparam logic [31:0] HALF_TURN        = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [23:0] freq;
    } tick_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [23:0] frequency
    logic [2:0]  s_tuser  = '0;   // [2:0] mode

    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;  // [15:0] sample

    tick_t       tick_q[$];
    logic [15:0] sample_q[$];
    int          sine_quarter[0:QUARTER_SIZE];

    logic [31:0]        phase_acc   = '0;
    logic [SCALE_W-1:0] scale_model = mwpo_pkg::SCALE_RESET;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_left   = 0;
    int cycle_count    = 0;
    int ticks_taken    = 0;
    int samples_checked = 0;
    int mismatches     = 0;
    int scale_settings = 1;

    multi_waveform_phase_oscillator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic int quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'(k) * PI_HALF_TURN_Q30) >> (mwpo_pkg::SINE_TABLE_BITS + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        if (sum > UNITY_Q30)
        begin
            sum = UNITY_Q30;
        end
        v = (sum * 64'(MAX_SAMPLE) + (UNITY_Q30 >> 1)) >> 30;
        if (v > 64'(MAX_SAMPLE))
        begin
            v = 64'(MAX_SAMPLE);
        end
        return int'(v);
    endfunction

    function automatic logic [15:0] oscillator_sample(input logic [2:0] mode,
                                                      input logic [31:0] p);
        int          v;
        logic [10:0] idx;
        case (mode)
            mwpo_pkg::MODE_SINE:
            begin
                idx = {1'b0, p[29:20]};
                if (p[30])
                begin
                    idx = 11'(QUARTER_SIZE) - idx;
                end
                v = sine_quarter[idx];
                if (p[31])
                begin
                    v = -v;
                end
            end
            mwpo_pkg::MODE_SQUARE:   v = (p <= HALF_TURN) ? FULL_SCALE : -FULL_SCALE;
            mwpo_pkg::MODE_SAW_DOWN: v = FULL_SCALE - int'(p[31:16]);
            mwpo_pkg::MODE_SAW_UP:   v = int'(p[31:16]) - FULL_SCALE;
            mwpo_pkg::MODE_TRIANGLE:
            begin
                if (p <= HALF_TURN)
                begin
                    v = int'(p[31:15]) - FULL_SCALE;
                end
                else
                begin
                    v = 3 * FULL_SCALE - int'(p[31:15]);
                end
            end
            default:       v = 0;
        endcase
        if (v > MAX_SAMPLE)
        begin
            v = MAX_SAMPLE;
        end
        if (v < -FULL_SCALE)
        begin
            v = -FULL_SCALE;
        end
        return v[15:0];
    endfunction

    function automatic logic [31:0] phase_increment(input logic signed [23:0] freq,
                                                    input logic [SCALE_W-1:0] scale);
        logic signed [63:0] f64;
        logic signed [63:0] s64;
        logic signed [63:0] prod;
        f64  = freq;
        s64  = {28'd0, scale};
        prod = f64 * s64;
        prod = prod >>> 24;
        return prod[31:0];
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    sel;
        sel    = $urandom_range(99);
        t.mode = (sel < 10) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        t.freq = 24'($urandom);
        sel    = $urandom_range(9);
        if (sel < 3)
        begin
            t.freq = {{12{t.freq[11]}}, t.freq[11:0]};
        end
        else if (sel == 3)
        begin
            case ($urandom_range(3))
                0:       t.freq = 24'sh7F_FFFF;
                1:       t.freq = 24'sh80_0000;
                2:       t.freq = '0;
                default: t.freq = '1;
            endcase
        end
        return t;
    endfunction

    // input side: offer queued ticks, predict on each accepted word
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        tick_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sample_q.push_back(oscillator_sample(s_tuser, phase_acc));
                phase_acc = phase_acc + phase_increment(s_tdata, scale_model);
                ticks_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = tick_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.freq;
                    s_tuser  <= nxt.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: stall at random, check each word against the oldest sample
    always @(posedge clk or negedge rst_n)
    begin : sample_monitor
        logic [15:0] want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    $display("%0t: sample mismatch: expected none, actual %0d",
                             $time, $signed(m_tdata[15:0]));
                    mismatches++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    samples_checked++;
                    if (m_tdata[15:0] !== want)
                    begin
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_tdata[15:0]));
                        mismatches++;
                    end
                end
            end
            m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d samples outstanding", $time, sample_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        if (addr == ADDR_PHASE_SCALE)
        begin
            scale_model = data[SCALE_W-1:0];
        end
    endtask

    task automatic check_scale();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PHASE_SCALE;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {28'd0, scale_model})
        begin
            $display("%0t: phase_scale mismatch: expected %0d, actual %0d",
                     $time, scale_model, prdata);
            mismatches++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_scale(input logic [63:0] data);
        write_reg(ADDR_PHASE_SCALE, data);
        check_scale();
        scale_settings++;
    endtask

    task automatic push_tick(input logic [2:0] mode, input logic signed [23:0] freq);
        tick_t t;
        t.mode = mode;
        t.freq = freq;
        tick_q.push_back(t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (tick_q.size() != 0 || s_tvalid || sample_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) tick_q.push_back(random_tick());
        wait_drained();
    endtask

    initial
    begin : stimulus
        for (int k = 0; k <= QUARTER_SIZE; k++)
        begin
            sine_quarter[k] = quarter_sine(k);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_scale();

        // 2^35 makes the step frequency * 2^11: quarter and half turns are exact
        set_scale({28'($urandom), 36'h8_0000_0000});
        push_tick(mwpo_pkg::MODE_SAW_DOWN, 24'sd524288);
        push_tick(mwpo_pkg::MODE_SINE,     24'sd524288);
        push_tick(mwpo_pkg::MODE_TRIANGLE, 24'sd0);
        push_tick(mwpo_pkg::MODE_SQUARE,   24'sd0);
        push_tick(mwpo_pkg::MODE_SAW_UP,   -24'sd1);
        push_tick(mwpo_pkg::MODE_SQUARE,   24'sd2);
        push_tick(mwpo_pkg::MODE_SQUARE,   24'sd0);
        push_tick(mwpo_pkg::MODE_TRIANGLE, 24'sd0);
        push_tick(mwpo_pkg::MODE_SINE,     24'sd0);
        push_tick(MODE_SPARE_A,            24'sh7F_FFFF);
        push_tick(MODE_SPARE_B,            24'sh80_0000);
        push_tick(MODE_SPARE_C,            -24'sd1);
        push_tick(mwpo_pkg::MODE_SAW_DOWN, 24'sd0);
        push_tick(mwpo_pkg::MODE_SINE,     24'sd1);
        push_tick(mwpo_pkg::MODE_TRIANGLE, 24'sh80_0000);
        push_tick(mwpo_pkg::MODE_SAW_UP,   24'sh7F_FFFF);
        push_tick(mwpo_pkg::MODE_SINE,     24'sh80_0000);
        push_tick(mwpo_pkg::MODE_SQUARE,   24'sh7F_FFFF);
        wait_drained();

        set_scale({28'($urandom), mwpo_pkg::SCALE_RESET});
        run_random(200, 0, 0);

        set_scale({28'($urandom), 36'd0});
        run_random(120, 86, 0);

        set_scale(64'hFFFF_FFFF_FFFF_FFFF);
        run_random(200, 0, 86);

        write_reg(ADDR_UNMAPPED, {$urandom, $urandom});
        check_scale();
        set_scale({$urandom, $urandom});
        run_random(200, 37, 37);

        // hold the output off while ticks keep coming so the pipe backs up
        set_scale({28'($urandom), 36'($urandom_range(1 << 26))});
        rx_hold_left <= 400;
        run_random(200, 0, 0);

        set_scale({28'($urandom), mwpo_pkg::SCALE_RESET});
        run_random(100, 86, 37);
        run_random(100, 37, 86);

        $display("covered %0d ticks and %0d checked samples over %0d scale settings,",
                 ticks_taken, samples_checked, scale_settings);
        $display("all five waveforms, unused modes, full-scale saturation and wrap");
        if (mismatches == 0 && sample_q.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
